// ----- sv/mlsd_pkg.sv -----
// Shared types, codes and reset values for the magic/length/suffix deframer.
`timescale 1ns / 1ps

package mlsd_pkg;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd2;

  // Reset values of the configuration registers
  localparam logic [31:0] MAGIC_WORD_RST = 32'hCAFE_BEBE;
  localparam logic [7:0]  TERMINATOR_RST = 8'h0A;
  localparam logic [31:0] MAX_LENGTH_RST = 32'd10485760;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_BAD_TERM  = 2'd3;

  typedef struct packed {
    logic       is_status;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [7:0]  terminator;
    logic [31:0] max_length;
  } cfg_t;

endpackage

// ----- sv/mlsd_parser.sv -----
// Frame parser: phase tracking, header checks and payload count.
`timescale 1ns / 1ps

module mlsd_parser
  import mlsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output result_t    res,
  output logic       halted
);

  localparam logic [2:0] PH_MAGIC   = 3'd0;
  localparam logic [2:0] PH_LENGTH  = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_TERM    = 3'd3;
  localparam logic [2:0] PH_HALTED  = 3'd4;

  logic [2:0]  phase, phase_next;
  logic [1:0]  byte_index, byte_index_next;
  logic        magic_mismatch, magic_mismatch_next;
  logic [31:0] length_accum, length_accum_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;

  logic [7:0]  want_byte;
  logic        mismatch_now;
  logic [31:0] accum_shift;
  logic        last_now;

  always_comb begin
    unique case (byte_index)
      2'd0:    want_byte = cfg.magic_word[31:24];
      2'd1:    want_byte = cfg.magic_word[23:16];
      2'd2:    want_byte = cfg.magic_word[15:8];
      default: want_byte = cfg.magic_word[7:0];
    endcase
  end

  assign mismatch_now = magic_mismatch | (rx_byte != want_byte);
  assign accum_shift  = {length_accum[23:0], rx_byte};
  assign last_now     = (bytes_remaining <= 32'd1);
  assign halted       = (phase == PH_HALTED);

  always_comb begin
    phase_next           = phase;
    byte_index_next      = byte_index;
    magic_mismatch_next  = magic_mismatch;
    length_accum_next    = length_accum;
    bytes_remaining_next = bytes_remaining;
    res_valid            = 1'b0;
    res                  = '0;
    if (accept) begin
      unique case (phase)
        PH_MAGIC: begin
          magic_mismatch_next = mismatch_now;
          if (byte_index == 2'd3) begin
            byte_index_next = 2'd0;
            if (mismatch_now) begin
              phase_next    = PH_HALTED;
              res_valid     = 1'b1;
              res.is_status = 1'b1;
              res.status    = ST_BAD_MAGIC;
            end else begin
              length_accum_next = '0;
              phase_next        = PH_LENGTH;
            end
          end else begin
            byte_index_next = byte_index + 2'd1;
          end
        end
        PH_LENGTH: begin
          length_accum_next = accum_shift;
          if (byte_index == 2'd3) begin
            byte_index_next = 2'd0;
            if (accum_shift > cfg.max_length) begin
              phase_next    = PH_HALTED;
              res_valid     = 1'b1;
              res.is_status = 1'b1;
              res.status    = ST_TOO_LARGE;
            end else begin
              bytes_remaining_next = accum_shift;
              phase_next = (accum_shift == 32'd0) ? PH_TERM : PH_PAYLOAD;
            end
          end else begin
            byte_index_next = byte_index + 2'd1;
          end
        end
        PH_PAYLOAD: begin
          if (bytes_remaining != 32'd0) begin
            bytes_remaining_next = bytes_remaining - 32'd1;
          end
          if (last_now) begin
            phase_next = PH_TERM;
          end
          res_valid     = 1'b1;
          res.data_byte = rx_byte;
          res.last_byte = last_now;
          res.status    = ST_OK;
        end
        PH_TERM: begin
          res_valid     = 1'b1;
          res.is_status = 1'b1;
          if (rx_byte != cfg.terminator) begin
            phase_next = PH_HALTED;
            res.status = ST_BAD_TERM;
          end else begin
            phase_next          = PH_MAGIC;
            byte_index_next     = 2'd0;
            magic_mismatch_next = 1'b0;
            length_accum_next   = '0;
            res.status          = ST_OK;
          end
        end
        default: begin
          // halted: drop every word until reset
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_MAGIC;
      byte_index      <= '0;
      magic_mismatch  <= 1'b0;
      length_accum    <= '0;
      bytes_remaining <= '0;
    end else begin
      phase           <= phase_next;
      byte_index      <= byte_index_next;
      magic_mismatch  <= magic_mismatch_next;
      length_accum    <= length_accum_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

// ----- sv/mlsd_out_buf.sv -----
// Two-entry output stage: result register plus skid register.
`timescale 1ns / 1ps

module mlsd_out_buf
  import mlsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_res,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    skid_valid;
  result_t skid_res;
  logic    main_busy;

  assign full      = skid_valid;
  assign main_busy = out_valid & out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_busy) begin
      // hold the result word; park a new one in the skid register
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= push;
    end else begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (main_busy) begin
      if (push) begin
        skid_res <= push_res;
      end
    end else if (skid_valid) begin
      out_res <= skid_res;
      if (push) begin
        skid_res <= push_res;
      end
    end else if (push) begin
      out_res <= push_res;
    end
  end

endmodule

// ----- sv/magic_length_suffix_deframer.sv -----
// Top level of the magic/length/suffix deframer.
`timescale 1ns / 1ps

// Takes one received byte per cycle while in_stall is low and splits the
// stream into frames of a 4-byte magic word, a 32-bit big-endian length,
// the payload and one terminator byte. Payload bytes go out as they arrive,
// the last one marked; each frame ends with a status word (ok, bad magic,
// too large, bad terminator). Any error halts the block, which then swallows
// all input until reset. One byte is taken every cycle unless in_stall is
// high; the parser result is combinational, so a result word is on the
// output in the cycle after its byte is accepted when the result register
// is free. Results pass through a two-entry output stage, so input stalls
// only once both the result register and the skid register hold words.
// Payload bytes leave before the terminator is checked, so drop a frame
// that ends in bad terminator. Configuration writes take effect at once
// and are meant for idle periods.

module magic_length_suffix_deframer
  import mlsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 is_status,
  output logic [7:0]           data_byte,
  output logic                 last_byte,
  output logic [1:0]           status
);

  cfg_t    cfg;
  logic    in_accept;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    halted;
  logic    buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_word <= MAGIC_WORD_RST;
      cfg.terminator <= TERMINATOR_RST;
      cfg.max_length <= MAX_LENGTH_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_MAGIC_WORD: cfg.magic_word <= wr_data;
        CFG_TERMINATOR: cfg.terminator <= wr_data[7:0];
        CFG_MAX_LENGTH: cfg.max_length <= wr_data;
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  assign in_stall  = buf_full;
  assign in_accept = in_valid & ~in_stall;

  mlsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .rx_byte   (rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res),
    .halted    (halted)
  );

  mlsd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_res  (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign is_status = out_res.is_status;
  assign data_byte = out_res.data_byte;
  assign last_byte = out_res.last_byte;
  assign status    = out_res.status;

  // skid register fills only behind a held result word
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid register full while result register empty");

  // a halted parser emits nothing
  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    (halted && in_accept) |-> !res_valid)
    else $error("result produced while halted");

  // every error status halts the parser
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.is_status && res.status != ST_OK) |=> halted)
    else $error("error status without halt");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the magic/length/suffix frame deframer.
`timescale 1ns / 1ps

module tb_top;
  import mlsd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  typedef enum logic [2:0] {
    PH_MAGIC, PH_LENGTH, PH_PAYLOAD, PH_TERM, PH_HALTED
  } deframe_phase_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [CFG_W-1:0]     wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           rx_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 is_status;
  logic [7:0]           data_byte;
  logic                 last_byte;
  logic [1:0]           status;

  // Shadow of the parser state and registers
  deframe_phase_t ph;
  logic [1:0]     hdr_idx;
  logic           magic_bad;
  logic [31:0]    len_acc;
  logic [31:0]    remaining;
  cfg_t           model_cfg;

  result_t deframed_q[$];
  result_t next_word;
  cfg_t    frame_cfg = '{MAGIC_WORD_RST, TERMINATOR_RST, MAX_LENGTH_RST};
  int      n_mismatch = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_len = 0;
  int      idle_cycles = 0;

  magic_length_suffix_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_status (is_status),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .status    (status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Returns 1 when the byte produces an output word.
  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [7:0] want;
    r = '0;
    case (ph)
      PH_MAGIC: begin
        want = 8'(model_cfg.magic_word >> (8 * (3 - hdr_idx)));
        if (b != want) magic_bad = 1'b1;
        if (hdr_idx == 2'd3) begin
          hdr_idx = '0;
          if (magic_bad) begin
            ph = PH_HALTED;
            r.is_status = 1'b1;
            r.status = ST_BAD_MAGIC;
            return 1'b1;
          end
          len_acc = '0;
          ph = PH_LENGTH;
        end else begin
          hdr_idx++;
        end
        return 1'b0;
      end
      PH_LENGTH: begin
        len_acc = {len_acc[23:0], b};
        if (hdr_idx == 2'd3) begin
          hdr_idx = '0;
          if (len_acc > model_cfg.max_length) begin
            ph = PH_HALTED;
            r.is_status = 1'b1;
            r.status = ST_TOO_LARGE;
            return 1'b1;
          end
          remaining = len_acc;
          if (remaining == 0) ph = PH_TERM;
          else ph = PH_PAYLOAD;
        end else begin
          hdr_idx++;
        end
        return 1'b0;
      end
      PH_PAYLOAD: begin
        r.data_byte = b;
        r.last_byte = (remaining <= 1);
        if (remaining != 0) remaining--;
        if (r.last_byte) ph = PH_TERM;
        return 1'b1;
      end
      PH_TERM: begin
        r.is_status = 1'b1;
        if (b != model_cfg.terminator) begin
          ph = PH_HALTED;
          r.status = ST_BAD_TERM;
          return 1'b1;
        end
        ph = PH_MAGIC;
        hdr_idx = '0;
        magic_bad = 1'b0;
        len_acc = '0;
        r.status = ST_OK;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_mismatch++;
    end
  endtask

  // Predict on accepted input, then check accepted output, then mirror writes.
  always @(posedge clk) begin
    if (rst) begin
      ph = PH_MAGIC;
      hdr_idx = '0;
      magic_bad = 1'b0;
      len_acc = '0;
      remaining = '0;
      model_cfg = '{MAGIC_WORD_RST, TERMINATOR_RST, MAX_LENGTH_RST};
    end else begin
      if (in_valid && !in_stall) begin
        if (deframe_byte(rx_byte, next_word)) deframed_q.push_back(next_word);
      end
      if (out_valid && !out_stall) begin
        if (deframed_q.size() == 0) begin
          $error("output word with none pending: is_status %0b data %0h last %0b status %0d",
                 is_status, data_byte, last_byte, status);
          n_mismatch++;
        end else begin
          next_word = deframed_q.pop_front();
          check_field("is_status", next_word.is_status, is_status);
          check_field("data_byte", next_word.data_byte, data_byte);
          check_field("last_byte", next_word.last_byte, last_byte);
          check_field("status", next_word.status, status);
        end
      end
      if (wr_en) begin
        case (wr_index)
          CFG_MAGIC_WORD: model_cfg.magic_word = wr_data;
          CFG_TERMINATOR: model_cfg.terminator = wr_data[7:0];
          CFG_MAX_LENGTH: model_cfg.max_length = wr_data;
          default: ;
        endcase
      end
    end
  end

  // Receiver: random stall, or a long hold when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("magic_length_suffix_deframer: mismatch");
      $finish;
    end
  end

  // Keep valid high across words; drop it only for idle cycles.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_word32(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  task automatic send_frame(input int unsigned len);
    send_word32(frame_cfg.magic_word);
    send_word32(len);
    repeat (len) send_byte(8'($urandom));
    send_byte(frame_cfg.terminator);
  endtask

  // Pause input until every pending word is out and the pipeline has settled.
  task automatic drain();
    in_valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    frame_cfg = c;
    wr_en <= 1'b1;
    wr_index <= CFG_MAGIC_WORD;
    wr_data <= c.magic_word;
    @(posedge clk);
    wr_index <= CFG_TERMINATOR;
    wr_data <= {24'($urandom), c.terminator};
    @(posedge clk);
    wr_index <= CFG_MAX_LENGTH;
    wr_data <= c.max_length;
    @(posedge clk);
    // unmapped index must not disturb anything
    wr_index <= CFG_UNUSED;
    wr_data <= $urandom;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic test_directed();
    cfg_t c;
    // zero length: next byte after the header is the terminator
    send_frame(0);
    send_word32(frame_cfg.magic_word);
    send_word32(32'd4);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_byte(frame_cfg.terminator);
    // length equal to the limit is accepted
    drain();
    c = '{MAGIC_WORD_RST, TERMINATOR_RST, 32'd2};
    load_config(c);
    send_frame(2);
  endtask

  task automatic test_random_frames(input cfg_t c, input int unsigned n_bytes,
                                    input logic [31:0] cap);
    int unsigned sent;
    int unsigned len;
    logic [31:0] top;
    drain();
    load_config(c);
    top = (c.max_length < cap) ? c.max_length : cap;
    sent = 0;
    while (sent < n_bytes) begin
      // mostly short frames, now and then up to the cap
      if ($urandom_range(7) == 0) len = $urandom_range(top, 0);
      else len = $urandom_range((top < 6) ? top : 6, 0);
      send_frame(len);
      sent += len + 9;
    end
  endtask

  task automatic test_backpressure();
    cfg_t c;
    drain();
    c = '{$urandom, 8'($urandom), 32'd1000};
    load_config(c);
    hold_len = 60;
    send_frame(30);
    drain();
  endtask

  task automatic test_error_halt();
    cfg_t c;
    logic [1:0] fault;
    logic [7:0] flip;
    int unsigned pos;
    int unsigned len;
    c.magic_word = $urandom;
    c.terminator = 8'($urandom);
    c.max_length = $urandom_range(64);
    drain();
    load_config(c);
    send_frame($urandom_range(c.max_length, 0));
    flip = 8'($urandom_range(255, 1));
    fault = 2'($urandom_range(ST_BAD_TERM, ST_BAD_MAGIC));
    case (fault)
      ST_BAD_MAGIC: begin
        pos = $urandom_range(3);
        send_word32(c.magic_word ^ (32'(flip) << (8 * pos)));
      end
      ST_TOO_LARGE: begin
        send_word32(c.magic_word);
        send_word32($urandom_range(32'hFFFF_FFFF, c.max_length + 1));
      end
      default: begin
        len = $urandom_range((c.max_length < 3) ? c.max_length : 3, 0);
        send_word32(c.magic_word);
        send_word32(len);
        repeat (len) send_byte(8'($urandom));
        send_byte(c.terminator ^ flip);
      end
    endcase
    // halted: everything after this is swallowed
    repeat (20) send_byte(8'($urandom));
  endtask

  initial begin
    cfg_t c;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 18;
    recv_stall_pct = 54;
    test_directed();
    test_random_frames('{MAGIC_WORD_RST, TERMINATOR_RST, MAX_LENGTH_RST}, 70, 12);

    send_idle_pct = 54;
    recv_stall_pct = 18;
    c = '{$urandom, 8'($urandom), 32'd4};
    test_random_frames(c, 70, 12);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    test_random_frames('{32'h0, 8'h00, 32'h0}, 40, 12);
    test_random_frames('{32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF}, 60, 40);
    test_error_halt();

    drain();
    repeat (20) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("magic_length_suffix_deframer: match");
    end else begin
      $display("magic_length_suffix_deframer: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mlsd_pkg.sv
sv/mlsd_parser.sv
sv/mlsd_out_buf.sv
sv/magic_length_suffix_deframer.sv
sim/tb_top.sv
